### design/rfe_pkg.sv
// ----------------------------------------------------------------------------
// rfe_pkg
// Shared constants, types and helper functions for the RTC field to epoch
// seconds converter.
// ----------------------------------------------------------------------------
package rfe_pkg;

   localparam int NumStages = 6;

   localparam logic [7:0] FLAG_BINARY = 8'h04;
   localparam logic [7:0] FLAG_24HOUR = 8'h02;
   localparam logic [7:0] PM_BIT      = 8'h80;
   localparam logic [7:0] HOUR_MASK   = 8'h7F;

   localparam logic [11:0] BASE_YEAR_RESET = 12'd2000;

   localparam logic signed [21:0] DAYS_PER_ERA = 22'sd146097;
   localparam logic [31:0] EPOCH_DAY_OFFSET    = 32'd719468;
   localparam logic [31:0] SECS_PER_DAY        = 32'd86400;

   typedef struct packed {
      logic [NumStages-1:0] load;
   } pipe_ctl_type;

   // Decoded clock fields after the first stage.
   typedef struct packed {
      logic [7:0]         sec;
      logic [7:0]         min;
      logic [7:0]         hour;
      logic [7:0]         dom;
      logic [7:0]         mp;
      logic signed [13:0] year;
   } dec_type;

   // Day count and time of day ahead of the final scaling.
   typedef struct packed {
      logic [31:0] days;
      logic [19:0] hms;
   } cal_type;

   function automatic logic [7:0] bcd_decode(input logic [7:0] v);
      return {4'b0, v[3:0]} + {1'b0, v[7:4], 3'b0} + {3'b0, v[7:4], 1'b0};
   endfunction

   // Remainder by 24 for values below 192, by a reciprocal multiply.
   function automatic logic [7:0] mod24(input logic [7:0] x);
      logic [15:0] p;
      logic [2:0]  q;
      p = 16'(x) * 16'd171;
      q = p[14:12];
      return x - (8'({1'b0, q, 4'b0}) + 8'({2'b0, q, 3'b0}));
   endfunction

endpackage

### design/rfe_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// rfe_pipe_ctrl
// Valid bits and per-stage load enables; empty stages fill even while the
// output is stalled.
// ----------------------------------------------------------------------------
module rfe_pipe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rfe_pkg::pipe_ctl_type ctl
);
   import rfe_pkg::*;

   logic [NumStages-1:0] valid_ff;
   logic [NumStages-1:0] valid_in;
   logic [NumStages-1:0] ready;

   always_comb begin
      ready[NumStages-1] = !valid_ff[NumStages-1] || !rsp_stall;
      for (int k = NumStages - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      valid_in[0] = ready[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NumStages; k++) begin
         valid_in[k] = ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctl.load  = ready;
   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[NumStages-1];

   a_reset_clears: assert property (@(posedge clock) reset |=> valid_ff == '0)
      else $error("pipeline valid bits not cleared by reset");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid_ff[0])
      else $error("accepted item did not enter the first stage");

   a_free_output: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled although the output drains");

   a_item_count: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> $countones(valid_ff) == $countones($past(valid_ff))
         + int'($past(req_valid && !req_stall)) - int'($past(rsp_valid && !rsp_stall)))
      else $error("item lost or duplicated in the pipeline");

endmodule

### design/rfe_decode.sv
// ----------------------------------------------------------------------------
// rfe_decode
// First stage: BCD decode, 12 to 24 hour conversion, full year and the
// March-based month index.
// ----------------------------------------------------------------------------
module rfe_decode (
   input  logic                  clock,
   input  rfe_pkg::pipe_ctl_type ctl,
   input  logic [11:0]           base_year,
   input  logic [7:0]            raw_seconds,
   input  logic [7:0]            raw_minutes,
   input  logic [7:0]            raw_hour,
   input  logic [7:0]            raw_day,
   input  logic [7:0]            raw_month,
   input  logic [7:0]            raw_year,
   input  logic [7:0]            rtc_status,
   output rfe_pkg::dec_type      dec
);
   import rfe_pkg::*;

   dec_type     dec_ff;
   dec_type     dec_in;
   logic [7:0]  sec, min, hr, dom, mon, yr, hr24;
   logic [6:0]  h7;
   logic        pm;
   logic        early;
   logic [12:0] year_sum;

   always_comb begin
      if ((rtc_status & FLAG_BINARY) != 8'h00) begin
         sec = raw_seconds;
         min = raw_minutes;
         hr  = raw_hour;
         dom = raw_day;
         mon = raw_month;
         yr  = raw_year;
      end else begin
         sec = bcd_decode(raw_seconds);
         min = bcd_decode(raw_minutes);
         hr  = bcd_decode(raw_hour & HOUR_MASK) | (raw_hour & PM_BIT);
         dom = bcd_decode(raw_day);
         mon = bcd_decode(raw_month);
         yr  = bcd_decode(raw_year);
      end

      h7 = hr[6:0];
      pm = hr[7];
      if ((rtc_status & FLAG_24HOUR) != 8'h00) begin
         hr24 = hr;
      end else if (h7 == 7'd12) begin
         hr24 = pm ? 8'd12 : 8'd0;
      end else if (pm) begin
         hr24 = mod24({1'b0, h7} + 8'd12);
      end else begin
         hr24 = {1'b0, h7};
      end

      // January and February count as the last months of the previous year.
      early    = mon <= 8'd2;
      year_sum = {1'b0, base_year} + {5'b0, yr};

      dec_in.sec  = sec;
      dec_in.min  = min;
      dec_in.hour = hr24;
      dec_in.dom  = dom;
      dec_in.mp   = early ? mon + 8'd9 : mon - 8'd3;
      dec_in.year = $signed({1'b0, year_sum}) - (early ? 14'sd1 : 14'sd0);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         dec_ff <= dec_in;
      end
   end

   assign dec = dec_ff;

endmodule

### design/rfe_calendar.sv
// ----------------------------------------------------------------------------
// rfe_calendar
// Stages two to five: era split, day of year, day of era and the day count
// relative to 1970-01-01, with the time of day carried alongside.
// ----------------------------------------------------------------------------
module rfe_calendar (
   input  logic                  clock,
   input  rfe_pkg::pipe_ctl_type ctl,
   input  rfe_pkg::dec_type      dec,
   output rfe_pkg::cal_type      cal
);
   import rfe_pkg::*;

   // Stage 2
   logic signed [13:0] s2_year_ff;
   logic signed [4:0]  s2_era_ff, s2_era_in;
   logic [15:0]        s2_doy_num_ff, s2_doy_num_in;
   logic [7:0]         s2_dom_ff, s2_hr_ff, s2_min_ff, s2_sec_ff;
   logic [24:0]        era_prod;

   // Stage 3
   logic [8:0]         s3_yoe_ff, s3_yoe_in;
   logic signed [13:0] s3_doy_ff, s3_doy_in;
   logic signed [4:0]  s3_era_ff;
   logic [19:0]        s3_hms_ff, s3_hms_in;
   logic signed [13:0] era_x400, yoe_full;
   logic [31:0]        doy_prod;
   logic [12:0]        doy_q;

   // Stage 4
   logic signed [18:0] s4_doe_ff, s4_doe_in;
   logic signed [21:0] s4_era_days_ff, s4_era_days_in;
   logic [19:0]        s4_hms_ff;
   logic [17:0]        yoe_days;
   logic [1:0]         cent;

   // Stage 5
   logic [31:0]        s5_days_ff, s5_days_in;
   logic [19:0]        s5_hms_ff;

   // Year divided by 400 via reciprocal; only year -1 is negative.
   always_comb begin
      era_prod = 25'(dec.year[12:0]) * 25'd5243;
      if (dec.year < 0) begin
         s2_era_in = -5'sd1;
      end else begin
         s2_era_in = $signed({1'b0, era_prod[24:21]});
      end
      s2_doy_num_in = 16'(dec.mp) * 16'd153 + 16'd2;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[1]) begin
         s2_year_ff    <= dec.year;
         s2_era_ff     <= s2_era_in;
         s2_doy_num_ff <= s2_doy_num_in;
         s2_dom_ff     <= dec.dom;
         s2_hr_ff      <= dec.hour;
         s2_min_ff     <= dec.min;
         s2_sec_ff     <= dec.sec;
      end
   end

   always_comb begin
      era_x400  = 14'(s2_era_ff) * 14'sd400;
      yoe_full  = s2_year_ff - era_x400;
      s3_yoe_in = yoe_full[8:0];
      // Division by 5 via reciprocal.
      doy_prod  = 32'(s2_doy_num_ff) * 32'd52429;
      doy_q     = doy_prod[30:18];
      s3_doy_in = $signed({1'b0, doy_q}) + $signed({6'b0, s2_dom_ff}) - 14'sd1;
      s3_hms_in = 20'(s2_hr_ff) * 20'd3600 + 20'(s2_min_ff) * 20'd60 + 20'(s2_sec_ff);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[2]) begin
         s3_yoe_ff <= s3_yoe_in;
         s3_doy_ff <= s3_doy_in;
         s3_era_ff <= s2_era_ff;
         s3_hms_ff <= s3_hms_in;
      end
   end

   always_comb begin
      yoe_days = 18'(s3_yoe_ff) * 18'd365;
      cent     = 2'(int'(s3_yoe_ff >= 9'd100) + int'(s3_yoe_ff >= 9'd200)
                    + int'(s3_yoe_ff >= 9'd300));
      s4_doe_in = $signed({1'b0, yoe_days}) + $signed(19'(s3_yoe_ff[8:2]))
                  - $signed(19'(cent)) + 19'(s3_doy_ff);
      s4_era_days_in = 22'(s3_era_ff) * DAYS_PER_ERA;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[3]) begin
         s4_doe_ff      <= s4_doe_in;
         s4_era_days_ff <= s4_era_days_in;
         s4_hms_ff      <= s3_hms_ff;
      end
   end

   assign s5_days_in = 32'(s4_era_days_ff) + 32'(s4_doe_ff) - EPOCH_DAY_OFFSET;

   always_ff @(posedge clock) begin
      if (ctl.load[4]) begin
         s5_days_ff <= s5_days_in;
         s5_hms_ff  <= s4_hms_ff;
      end
   end

   assign cal.days = s5_days_ff;
   assign cal.hms  = s5_hms_ff;

endmodule

### design/rfe_scale.sv
// ----------------------------------------------------------------------------
// rfe_scale
// Last stage: days times 86400 plus the time of day, kept to 32 bits.
// ----------------------------------------------------------------------------
module rfe_scale (
   input  logic                  clock,
   input  rfe_pkg::pipe_ctl_type ctl,
   input  rfe_pkg::cal_type      cal,
   output logic [31:0]           epoch_seconds
);
   import rfe_pkg::*;

   logic [31:0] epoch_ff;
   logic [31:0] epoch_in;
   logic [31:0] day_secs;

   always_comb begin
      day_secs = cal.days * SECS_PER_DAY;
      epoch_in = day_secs + 32'(cal.hms);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[NumStages-1]) begin
         epoch_ff <= epoch_in;
      end
   end

   assign epoch_seconds = epoch_ff;

endmodule

### design/rtc_fields_to_epoch_seconds.sv
// Each item is registered through the decode, calendar and scale stages.
// Throughput: one item per cycle; the six-stage pipeline fills bubbles even
// while the output is stalled, so input stalls only when every stage is full.
// Reset clears all stage valid bits and sets the base year to 2000; the
// data registers are not reset.
// ----------------------------------------------------------------------------
// rtc_fields_to_epoch_seconds
// Converts raw RTC bytes (BCD or binary, 12 or 24 hour) into seconds since
// 1970-01-01, low 32 bits.
// ----------------------------------------------------------------------------
module rtc_fields_to_epoch_seconds (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_raw_seconds,
   input  logic [7:0]  req_raw_minutes,
   input  logic [7:0]  req_raw_hour,
   input  logic [7:0]  req_raw_day,
   input  logic [7:0]  req_raw_month,
   input  logic [7:0]  req_raw_year,
   input  logic [7:0]  req_rtc_status,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_epoch_seconds,
   input  logic        csr_wr_en,
   input  logic [11:0] csr_wr_data
);
   import rfe_pkg::*;

   logic [11:0]  base_year_ff;
   pipe_ctl_type ctl;
   dec_type      dec;
   cal_type      cal;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_year_ff <= BASE_YEAR_RESET;
      end else if (csr_wr_en) begin
         base_year_ff <= csr_wr_data;
      end
   end

   rfe_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl       (ctl)
   );

   rfe_decode u_decode (
      .clock       (clock),
      .ctl         (ctl),
      .base_year   (base_year_ff),
      .raw_seconds (req_raw_seconds),
      .raw_minutes (req_raw_minutes),
      .raw_hour    (req_raw_hour),
      .raw_day     (req_raw_day),
      .raw_month   (req_raw_month),
      .raw_year    (req_raw_year),
      .rtc_status  (req_rtc_status),
      .dec         (dec)
   );

   rfe_calendar u_calendar (
      .clock (clock),
      .ctl   (ctl),
      .dec   (dec),
      .cal   (cal)
   );

   rfe_scale u_scale (
      .clock         (clock),
      .ctl           (ctl),
      .cal           (cal),
      .epoch_seconds (rsp_epoch_seconds)
   );

endmodule

### sim/rtc_fields_to_epoch_seconds_test.sv
// ----------------------------------------------------------------------------
// rtc_fields_to_epoch_seconds_test
// Self-checking bench for the RTC field to epoch seconds converter. Clock
// readings go in through a queue-fed driver, an in-bench calculation of the
// days-from-civil arithmetic predicts each timestamp, and a monitor compares
// every result in order. The base year register is stepped through its
// extremes and typical centuries between phases while both sides stall at
// random in all phases but one.
// ----------------------------------------------------------------------------
module rtc_fields_to_epoch_seconds_test;
   timeunit 1ns;
   timeprecision 1ps;
   import rfe_pkg::*;

   localparam int CycleLimit    = 200000;
   localparam int SettleCycles  = 20;
   localparam int NumPhases     = 7;
   localparam int ChunksPerPhase = 4;
   localparam int ChunkSize     = 66;

   localparam longint DaysPerEra     = 146097;
   localparam longint DaysTo1970     = 719468;
   localparam longint SecondsPerDay  = 86400;

   localparam logic [7:0] ModeBcd12 = 8'h00;
   localparam logic [7:0] ModeBcd24 = FLAG_24HOUR;
   localparam logic [7:0] ModeBin12 = FLAG_BINARY;
   localparam logic [7:0] ModeBin24 = FLAG_BINARY | FLAG_24HOUR;

   typedef struct packed {
      logic [7:0] secs;
      logic [7:0] mins;
      logic [7:0] hours;
      logic [7:0] mday;
      logic [7:0] mon;
      logic [7:0] yr;
      logic [7:0] status;
   } rtc_read_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_raw_seconds = '0;
   logic [7:0]  req_raw_minutes = '0;
   logic [7:0]  req_raw_hour = '0;
   logic [7:0]  req_raw_day = '0;
   logic [7:0]  req_raw_month = '0;
   logic [7:0]  req_raw_year = '0;
   logic [7:0]  req_rtc_status = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_epoch_seconds;
   logic        csr_wr_en = 1'b0;
   logic [11:0] csr_wr_data = '0;

   rtc_read_type clock_reads_q[$];
   logic [31:0]  epoch_expected_q[$];
   rtc_read_type next_read;
   logic [11:0]  base_year_model = BASE_YEAR_RESET;
   logic [11:0]  base_plan[NumPhases];
   logic         req_taken = 1'b0;
   int           idle_pct = 25;
   int           reads_issued = 0;
   int           results_seen = 0;
   int           errors = 0;
   int           cycle_count = 0;

   rtc_fields_to_epoch_seconds u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_raw_seconds   (req_raw_seconds),
      .req_raw_minutes   (req_raw_minutes),
      .req_raw_hour      (req_raw_hour),
      .req_raw_day       (req_raw_day),
      .req_raw_month     (req_raw_month),
      .req_raw_year      (req_raw_year),
      .req_rtc_status    (req_rtc_status),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_epoch_seconds (rsp_epoch_seconds),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int unsigned bcd_value(input logic [7:0] v);
      return v[3:0] + 10 * v[7:4];
   endfunction

   function automatic logic [7:0] clock_byte(input int unsigned v, input logic binary);
      return binary ? 8'(v) : {4'(v / 10), 4'(v % 10)};
   endfunction

   // Seconds since 1970 for one clock reading, low 32 bits.
   function automatic logic [31:0] epoch_of(input rtc_read_type r, input logic [11:0] base);
      int unsigned s, m, h, d, mo, y, h7;
      logic        pm;
      longint      yy, mm, era, yoe, doy, doe, days, total;
      s  = r.secs;
      m  = r.mins;
      h  = r.hours;
      d  = r.mday;
      mo = r.mon;
      y  = r.yr;
      if ((r.status & FLAG_BINARY) == 0) begin
         s  = bcd_value(r.secs);
         m  = bcd_value(r.mins);
         h  = bcd_value(r.hours & HOUR_MASK) | (r.hours & PM_BIT);
         d  = bcd_value(r.mday);
         mo = bcd_value(r.mon);
         y  = bcd_value(r.yr);
      end
      // In 24-hour mode a set PM flag simply stays in the hour value.
      if ((r.status & FLAG_24HOUR) == 0) begin
         pm = (h & PM_BIT) != 0;
         h7 = h & HOUR_MASK;
         if (h7 == 12) begin
            h = pm ? 12 : 0;
         end else if (pm) begin
            h = (h7 + 12) % 24;
         end else begin
            h = h7;
         end
      end
      yy = longint'(base) + longint'(y);
      mm = longint'(mo);
      if (mm <= 2) begin
         yy = yy - 1;
      end
      era   = (yy >= 0 ? yy : yy - 399) / 400;
      yoe   = yy - era * 400;
      doy   = (153 * (mm + (mm > 2 ? -3 : 9)) + 2) / 5 + longint'(d) - 1;
      doe   = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      days  = era * DaysPerEra + doe - DaysTo1970;
      total = days * SecondsPerDay + longint'(h) * 3600 + longint'(m) * 60 + longint'(s);
      return total[31:0];
   endfunction

   // Mostly plausible clock readings in a random mode, some pure noise.
   function automatic rtc_read_type random_read();
      rtc_read_type r;
      logic         binary;
      int unsigned  hr;
      r = 56'({$urandom, $urandom});
      if ($urandom_range(99) < 15) begin
         return r;
      end
      binary = (r.status & FLAG_BINARY) != 0;
      if ((r.status & FLAG_24HOUR) != 0) begin
         hr = $urandom_range(23);
         r.hours = clock_byte(hr, binary);
      end else begin
         hr = $urandom_range(12, 1);
         r.hours = clock_byte(hr, binary) | ($urandom_range(1) ? PM_BIT : 8'h00);
      end
      r.secs = clock_byte($urandom_range(59), binary);
      r.mins = clock_byte($urandom_range(59), binary);
      r.mday = clock_byte($urandom_range(31, 1), binary);
      r.mon  = clock_byte($urandom_range(12, 1), binary);
      r.yr   = clock_byte($urandom_range(99), binary);
      return r;
   endfunction

   task automatic queue_read(input rtc_read_type r);
      clock_reads_q.push_back(r);
      reads_issued++;
   endtask

   task automatic wait_drained();
      while (results_seen < reads_issued) begin
         @(negedge clock);
      end
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (clock_reads_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
            next_read = clock_reads_q.pop_front();
            req_raw_seconds <= next_read.secs;
            req_raw_minutes <= next_read.mins;
            req_raw_hour    <= next_read.hours;
            req_raw_day     <= next_read.mday;
            req_raw_month   <= next_read.mon;
            req_raw_year    <= next_read.yr;
            req_rtc_status  <= next_read.status;
            req_valid       <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < idle_pct);
   end

   always @(posedge clock) begin
      logic [31:0] want;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            epoch_expected_q.push_back(epoch_of({req_raw_seconds, req_raw_minutes,
               req_raw_hour, req_raw_day, req_raw_month, req_raw_year, req_rtc_status},
               base_year_model));
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (epoch_expected_q.size() == 0) begin
               $display("%0t: unexpected item, expected none, actual %h",
                        $time, rsp_epoch_seconds);
               errors++;
            end else begin
               want = epoch_expected_q.pop_front();
               if (rsp_epoch_seconds !== want) begin
                  $display("%0t: epoch seconds mismatch, expected %h, actual %h",
                           $time, want, rsp_epoch_seconds);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("FAIL rtc_fields_to_epoch_seconds");
         $finish;
      end
   end

   initial begin
      base_plan = '{BASE_YEAR_RESET, 12'd0, 12'd4095, 12'd1900, 12'd2100, 12'd1970, 12'd0};
      base_plan[NumPhases-1] = 12'($urandom_range(4095));
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int p = 0; p < NumPhases; p++) begin
         if (p > 0) begin
            wait_drained();
            @(negedge clock);
            csr_wr_en   <= 1'b1;
            csr_wr_data <= base_plan[p];
            @(negedge clock);
            csr_wr_en   <= 1'b0;
            base_year_model = base_plan[p];
         end
         // One phase runs without any idling on either side.
         idle_pct = (p == 3) ? 0 : 25;

         case (p)
            0: begin
               queue_read({8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, ModeBcd24});
               // Last second before the signed 32-bit rollover, then the rollover.
               queue_read({8'd7, 8'd14, 8'd3, 8'd19, 8'd1, 8'd38, ModeBin24});
               queue_read({8'd8, 8'd14, 8'd3, 8'd19, 8'd1, 8'd38, ModeBin24});
               // Last second of the unsigned 32-bit range, then the wrap to zero.
               queue_read({8'd15, 8'd28, 8'd6, 8'd7, 8'd2, 8'd106, ModeBin24});
               queue_read({8'd16, 8'd28, 8'd6, 8'd7, 8'd2, 8'd106, ModeBin24});
               // Midnight, noon, late evening and early morning in 12-hour time.
               queue_read({8'h30, 8'h45, 8'h12, 8'h15, 8'h06, 8'h24, ModeBcd12});
               queue_read({8'h30, 8'h45, 8'h92, 8'h15, 8'h06, 8'h24, ModeBcd12});
               queue_read({8'h30, 8'h45, 8'h91, 8'h15, 8'h06, 8'h24, ModeBcd12});
               queue_read({8'h30, 8'h45, 8'h01, 8'h15, 8'h06, 8'h24, ModeBcd12});
               queue_read({8'd0, 8'd0, 8'd12, 8'd1, 8'd7, 8'd50, ModeBin12});
               // PM flag left set in 24-hour mode.
               queue_read({8'h00, 8'h00, 8'h85, 8'h10, 8'h10, 8'h10, ModeBcd24});
               // Out-of-range hour with PM flag in binary 12-hour mode.
               queue_read({8'd1, 8'd2, 8'hFF, 8'd3, 8'd4, 8'd5, ModeBin12});
               // Invalid BCD nibbles everywhere, and every byte at its maximum.
               queue_read({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, ModeBcd12});
               queue_read({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
               // Month and day of zero.
               queue_read({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, ModeBcd24});
               // Leap day and the following March day.
               queue_read({8'h59, 8'h59, 8'h23, 8'h29, 8'h02, 8'h00, ModeBcd24});
               queue_read({8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00, ModeBcd24});
               queue_read({8'd0, 8'd0, 8'd0, 8'd1, 8'd13, 8'd20, ModeBin24});
               // Unused status bits set while both mode bits are clear.
               queue_read({8'h07, 8'h08, 8'h89, 8'h11, 8'h11, 8'h11, 8'hF9});
               queue_read({8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, ModeBcd24});
            end
            1: begin
               // A zero base year with a January date reaches a negative year.
               queue_read({8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd0, ModeBin24});
            end
            2: begin
               queue_read({8'd59, 8'd59, 8'd23, 8'd31, 8'd12, 8'd255, ModeBin24});
            end
            default: begin
            end
         endcase

         for (int c = 0; c < ChunksPerPhase; c++) begin
            while (clock_reads_q.size() > 8) begin
               @(negedge clock);
            end
            for (int i = 0; i < ChunkSize; i++) begin
               queue_read(random_read());
            end
            // Now and then hold the sender back until the pipeline is empty.
            if (c == 1 && (p % 3) == 1) begin
               wait_drained();
            end
         end
      end

      wait_drained();
      repeat (SettleCycles) @(posedge clock);
      if (epoch_expected_q.size() != 0) begin
         $display("%0t: %0d expected items never arrived, next expected %h, actual none",
                  $time, epoch_expected_q.size(), epoch_expected_q[0]);
         errors++;
      end
      if (errors == 0) begin
         $display("PASS rtc_fields_to_epoch_seconds");
      end else begin
         $display("FAIL rtc_fields_to_epoch_seconds");
      end
      $finish;
   end

endmodule

### sim.f
design/rfe_pkg.sv
design/rfe_pipe_ctrl.sv
design/rfe_decode.sv
design/rfe_calendar.sv
design/rfe_scale.sv
design/rtc_fields_to_epoch_seconds.sv
sim/rtc_fields_to_epoch_seconds_test.sv
